/* src/read_terminator_detector_unit_assert.svh */
// Assertion macros used by the checker module of this block.
`ifndef READ_TERMINATOR_DETECTOR_UNIT_ASSERT_SVH
`define READ_TERMINATOR_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define RTD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define RTD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rtd_pkg.sv */
package rtd_pkg;

    localparam int TOKEN_MAX   = 8;
    localparam int INDEX_WIDTH = 16;
    localparam int TOK_IDX_W   = $clog2(TOKEN_MAX);
    localparam int TOK_W       = 8 * TOKEN_MAX;
    localparam int MATCH_W     = 4;
    localparam int CAP_W       = INDEX_WIDTH + 1;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TERM_KIND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_FOUND    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_FAILED   = 3'd3;
    localparam logic [2:0] ST_IDLE     = 3'd4;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       start_read;
    } t_in_item;

    typedef struct packed {
        logic                   store_valid;
        logic [INDEX_WIDTH-1:0] store_index;
        logic                   done_res;
        logic [2:0]             status;
        logic [INDEX_WIDTH-1:0] stored_total;
        logic [MATCH_W-1:0]     matched_length;
    } t_out_item;

    // Live configuration after clamping, as seen by the sequencer.
    typedef struct packed {
        logic                   term_kind;
        logic [7:0]             delim_byte;
        logic [TOK_W-1:0]       token;
        logic [MATCH_W-1:0]     tok_len;
        logic [INDEX_WIDTH-1:0] store_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_EXEC,
        S_WALK,
        S_EMIT
    } t_state;

    function automatic logic [7:0] tok_byte(input logic [TOK_W-1:0] tok,
                                            input logic [TOK_IDX_W-1:0] k);
        return tok[8*k +: 8];
    endfunction

endpackage

/* src/rtd_cfg.sv */
module rtd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rtd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtd_pkg::TOK_W-1:0]      i_cfg_data,
    output rtd_pkg::t_cfg                  o_cfg
);

    localparam logic [rtd_pkg::CAP_W-1:0] CAP_MIN = rtd_pkg::CAP_W'(2);
    localparam logic [rtd_pkg::CAP_W-1:0] CAP_TOP = rtd_pkg::CAP_W'(1) << rtd_pkg::INDEX_WIDTH;

    logic                          r_kind;
    logic [7:0]                    r_delim;
    logic [rtd_pkg::TOK_W-1:0]     r_token;
    logic [rtd_pkg::MATCH_W-1:0]   r_tok_len;
    logic [rtd_pkg::CAP_W-1:0]     r_cap;
    logic [rtd_pkg::CAP_W-1:0]     cap_clamped;
    logic [rtd_pkg::CAP_W-1:0]     limit_full;
    logic [rtd_pkg::MATCH_W-1:0]   len_clamped;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= 1'b0;
            r_delim   <= 8'd10;
            r_token   <= '0;
            r_tok_len <= rtd_pkg::MATCH_W'(1);
            r_cap     <= rtd_pkg::CAP_W'(256);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rtd_pkg::REG_TERM_KIND:  r_kind    <= i_cfg_data[0];
                rtd_pkg::REG_DELIM_BYTE: r_delim   <= i_cfg_data[7:0];
                rtd_pkg::REG_TOKEN:      r_token   <= i_cfg_data;
                rtd_pkg::REG_TOKEN_LEN:  r_tok_len <= i_cfg_data[rtd_pkg::MATCH_W-1:0];
                rtd_pkg::REG_CAPACITY:   r_cap     <= i_cfg_data[rtd_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_cap < CAP_MIN) begin
            cap_clamped = CAP_MIN;
        end else if (r_cap > CAP_TOP) begin
            cap_clamped = CAP_TOP;
        end else begin
            cap_clamped = r_cap;
        end

        priority if (r_tok_len == '0) begin
            len_clamped = rtd_pkg::MATCH_W'(1);
        end else if (r_tok_len > rtd_pkg::MATCH_W'(rtd_pkg::TOKEN_MAX)) begin
            len_clamped = rtd_pkg::MATCH_W'(rtd_pkg::TOKEN_MAX);
        end else begin
            len_clamped = r_tok_len;
        end
    end

    assign limit_full = cap_clamped - rtd_pkg::CAP_W'(1);

    assign o_cfg.term_kind   = r_kind;
    assign o_cfg.delim_byte  = r_delim;
    assign o_cfg.token       = r_token;
    assign o_cfg.tok_len     = len_clamped;
    assign o_cfg.store_limit = limit_full[rtd_pkg::INDEX_WIDTH-1:0];

endmodule

/* src/rtd_seq.sv */
module rtd_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtd_pkg::t_cfg       i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rtd_pkg::t_in_item   i_in_data,
    input  logic                i_emit_ok,
    output logic                o_res_valid,
    output rtd_pkg::t_out_item  o_res
);

    rtd_pkg::t_state                     r_state, n_state;
    rtd_pkg::t_in_item                   r_item, n_item;
    rtd_pkg::t_out_item                  r_res, n_res;
    logic                                r_active, n_active;
    logic [rtd_pkg::INDEX_WIDTH-1:0]     r_stored, n_stored;
    logic [rtd_pkg::MATCH_W-1:0]         r_match, n_match;
    logic [rtd_pkg::MATCH_W-1:0]         r_i, n_i;
    logic [rtd_pkg::TOK_IDX_W-1:0]       r_len, n_len;
    logic [rtd_pkg::MATCH_W-1:0]         r_m, n_m;
    logic [rtd_pkg::TOK_IDX_W-1:0]       r_ft [rtd_pkg::TOKEN_MAX];

    logic                                ft_clear;
    logic                                ft_we;
    logic [rtd_pkg::TOK_IDX_W-1:0]       ft_waddr;
    logic [rtd_pkg::TOK_IDX_W-1:0]       ft_wdata;
    logic [rtd_pkg::TOK_IDX_W-1:0]       ft_raddr;
    logic [rtd_pkg::TOK_IDX_W-1:0]       ft_rd;
    logic [rtd_pkg::TOK_IDX_W-1:0]       tok_sel;
    logic [7:0]                          cmp_a;
    logic [7:0]                          cmp_b;
    logic                                cmp_eq;
    logic [rtd_pkg::INDEX_WIDTH-1:0]     stored_inc;
    logic [rtd_pkg::MATCH_W-1:0]         m_fin;

    // The one byte comparator, shared by table build, match walk and
    // delimiter check.
    always_comb begin
        tok_sel = (r_state == rtd_pkg::S_BUILD) ? r_len : r_m[rtd_pkg::TOK_IDX_W-1:0];
        cmp_a   = (r_state == rtd_pkg::S_BUILD)
                ? rtd_pkg::tok_byte(i_cfg.token, r_i[rtd_pkg::TOK_IDX_W-1:0])
                : r_item.rx_byte;
        cmp_b   = (r_state == rtd_pkg::S_EXEC) ? i_cfg.delim_byte
                : rtd_pkg::tok_byte(i_cfg.token, tok_sel);
        cmp_eq  = (cmp_a == cmp_b);
        ft_raddr = tok_sel - rtd_pkg::TOK_IDX_W'(1);
        ft_rd    = r_ft[ft_raddr];
    end

    assign stored_inc = r_stored + rtd_pkg::INDEX_WIDTH'(1);
    assign m_fin      = cmp_eq ? (r_m + rtd_pkg::MATCH_W'(1)) : r_m;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_res       = r_res;
        n_active    = r_active;
        n_stored    = r_stored;
        n_match     = r_match;
        n_i         = r_i;
        n_len       = r_len;
        n_m         = r_m;
        ft_clear    = 1'b0;
        ft_we       = 1'b0;
        ft_waddr    = r_i[rtd_pkg::TOK_IDX_W-1:0];
        ft_wdata    = r_len + rtd_pkg::TOK_IDX_W'(1);
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            rtd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item = i_in_data;
                    if (i_in_data.start_read) begin
                        n_stored = '0;
                        n_match  = '0;
                        n_active = 1'b1;
                        n_i      = rtd_pkg::MATCH_W'(1);
                        n_len    = '0;
                        ft_clear = 1'b1;
                        n_state  = rtd_pkg::S_BUILD;
                    end else begin
                        n_state = rtd_pkg::S_EXEC;
                    end
                end
            end

            rtd_pkg::S_BUILD: begin
                // One step of the prefix-table loop per cycle.
                priority if (r_i >= i_cfg.tok_len) begin
                    n_state = rtd_pkg::S_EXEC;
                end else if (cmp_eq) begin
                    ft_we = 1'b1;
                    n_len = r_len + rtd_pkg::TOK_IDX_W'(1);
                    n_i   = r_i + rtd_pkg::MATCH_W'(1);
                end else if (r_len != '0) begin
                    n_len = ft_rd;
                end else begin
                    n_i = r_i + rtd_pkg::MATCH_W'(1);
                end
            end

            rtd_pkg::S_EXEC: begin
                n_res   = '0;
                n_state = rtd_pkg::S_EMIT;
                priority if (!r_active) begin
                    n_res.status         = rtd_pkg::ST_IDLE;
                    n_res.stored_total   = r_stored;
                    n_res.matched_length = r_match;
                end else if (i_cfg.term_kind) begin
                    if (r_item.mode) begin
                        n_res.done_res       = 1'b1;
                        n_res.status         = rtd_pkg::ST_FAILED;
                        n_res.matched_length = r_match;
                        n_active             = 1'b0;
                    end else begin
                        n_m     = (r_match >= i_cfg.tok_len) ? '0 : r_match;
                        n_state = rtd_pkg::S_WALK;
                    end
                end else begin
                    n_res.store_index  = r_stored;
                    n_res.stored_total = r_stored;
                    priority if (r_item.mode) begin
                        n_res.done_res = 1'b1;
                        n_res.status   = rtd_pkg::ST_FAILED;
                    end else if (r_stored >= i_cfg.store_limit) begin
                        n_res.done_res = 1'b1;
                        n_res.status   = rtd_pkg::ST_OVERFLOW;
                    end else if (cmp_eq) begin
                        n_res.done_res = 1'b1;
                        n_res.status   = rtd_pkg::ST_FOUND;
                    end else begin
                        n_res.store_valid  = 1'b1;
                        n_res.stored_total = stored_inc;
                        n_stored           = stored_inc;
                        if (stored_inc >= i_cfg.store_limit) begin
                            n_res.done_res = 1'b1;
                            n_res.status   = rtd_pkg::ST_OVERFLOW;
                        end
                    end
                    if (n_res.done_res) begin
                        n_active = 1'b0;
                    end
                end
            end

            rtd_pkg::S_WALK: begin
                // Follow the failure chain one link per cycle.
                if (r_m != '0 && !cmp_eq) begin
                    n_m = {1'b0, ft_rd};
                end else begin
                    n_res                = '0;
                    n_res.matched_length = m_fin;
                    n_match              = m_fin;
                    if (m_fin >= i_cfg.tok_len) begin
                        n_res.done_res = 1'b1;
                        n_res.status   = rtd_pkg::ST_FOUND;
                        n_active       = 1'b0;
                    end
                    n_state = rtd_pkg::S_EMIT;
                end
            end

            rtd_pkg::S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_emit_ok) begin
                    n_state = rtd_pkg::S_IDLE;
                end
            end

            default: n_state = rtd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rtd_pkg::S_IDLE;
            r_active <= 1'b0;
            r_stored <= '0;
            r_match  <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_stored <= n_stored;
            r_match  <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_i    <= n_i;
        r_len  <= n_len;
        r_m    <= n_m;
        if (ft_clear) begin
            for (int k = 0; k < rtd_pkg::TOKEN_MAX; k++) begin
                r_ft[k] <= '0;
            end
        end else if (ft_we) begin
            r_ft[ft_waddr] <= ft_wdata;
        end
    end

    assign o_res = r_res;

endmodule

/* src/read_terminator_detector_unit.sv */
// Read terminator detector.
// Each input request carries one received byte (or a failure event) of an
// ongoing read, with start_read marking the first request of a new read.
// Every request yields exactly one result request on the output channel.
// A separate configuration channel writes the terminator kind, delimiter,
// token, token length and buffer capacity; it is always ready.
// A request is taken while the sequencer is idle. A delimiter-mode or
// idle request goes through the execute state to the emit state and then
// into the output register; a token-mode byte first walks the failure
// chain, link by link, through the shared byte comparator. A start_read
// request first rebuilds the failure table through that same comparator.
// The sequencer is not ready meanwhile; it returns to idle once its
// result has moved on, and only then takes the next request.
// The output register lets the next request be taken while a result still
// waits; if the receiver stalls further, the sequencer holds its result
// and stops taking requests. Synchronous active-low reset empties the
// output register, ends any read and restores the configuration defaults.
module read_terminator_detector_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rtd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtd_pkg::TOK_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rtd_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rtd_pkg::t_out_item             o_out_data
);

    rtd_pkg::t_cfg       cfg;
    rtd_pkg::t_out_item  res;
    logic                res_valid;
    logic                emit_ok;
    logic                r_out_valid;
    rtd_pkg::t_out_item  r_out_data;

    rtd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rtd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_emit_ok   (emit_ok),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The output register can take a new result when empty or when its
    // current content leaves in this cycle.
    assign emit_ok = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && emit_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && emit_ok) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/rtd_checker.sv */
`include "read_terminator_detector_unit_assert.svh"

module rtd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rtd_pkg::t_out_item  o_out_data
);

    // The sequencer works on one request at a time.
    `RTD_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "request taken while busy")

    // A request seen outside a read neither ends a read nor stores.
    `RTD_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, o_out_valid && o_out_data.status == rtd_pkg::ST_IDLE, !o_out_data.done_res && !o_out_data.store_valid, "idle result has side effects")

    // The read ends exactly when the status names an ending.
    `RTD_ASSERT_IMP(a_done_status, i_clk, i_rst_n, o_out_valid, o_out_data.done_res == (o_out_data.status == rtd_pkg::ST_FOUND || o_out_data.status == rtd_pkg::ST_OVERFLOW || o_out_data.status == rtd_pkg::ST_FAILED), "done flag disagrees with status")

    // A stored byte belongs to delimiter mode and never to a terminator.
    `RTD_ASSERT_IMP(a_store_kind, i_clk, i_rst_n, o_out_valid && o_out_data.store_valid, o_out_data.matched_length == '0 && (o_out_data.status == rtd_pkg::ST_RUNNING || o_out_data.status == rtd_pkg::ST_OVERFLOW), "store in wrong mode or status")

    // A stalled result stays put.
    `RTD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed")

endmodule

bind read_terminator_detector_unit rtd_checker u_rtd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
